// ----- hw/rtl/two_machine_makespan_dp_assert.svh -----
// ----------------------------------------------------------------------------
// two_machine_makespan_dp assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef TWO_MACHINE_MAKESPAN_DP_ASSERT_SVH
`define TWO_MACHINE_MAKESPAN_DP_ASSERT_SVH

// property must hold at every edge out of reset
`define TMM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true out of reset
`define TMM_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/tmm_pkg.sv -----
// ----------------------------------------------------------------------------
// tmm_pkg
// shared constants and types of the two-machine makespan block
// ----------------------------------------------------------------------------
`default_nettype none

package tmm_pkg;

	localparam int TIME_W = 13;
	localparam int MAX_TOTAL_DEF = 4096;
	localparam logic [TIME_W-1:0] VAL_CAP = 13'h1FFF;

	// controller to datapath commands
	typedef struct packed {
		logic take;
		logic rd;
		logic clr_wr;
		logic load_res;
	} cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tmm_task_if.sv -----
// ----------------------------------------------------------------------------
// tmm_task_if
// task channel: valid/ready handshake with task time and last-task mark
// ----------------------------------------------------------------------------
`default_nettype none

interface tmm_task_if;
	logic                          valid;
	logic                          ready;
	logic [tmm_pkg::TIME_W-1:0]    task_time;
	logic                          last_task;

	modport source (output valid, output task_time, output last_task, input ready);
	modport sink (input valid, input task_time, input last_task, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tmm_result_if.sv -----
// ----------------------------------------------------------------------------
// tmm_result_if
// result channel: valid/ready handshake with makespan and overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

interface tmm_result_if;
	logic                          valid;
	logic                          ready;
	logic [tmm_pkg::TIME_W-1:0]    makespan;
	logic                          overflow;

	modport source (output valid, output makespan, output overflow, input ready);
	modport sink (input valid, input makespan, input overflow, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tmm_datapath.sv -----
// ----------------------------------------------------------------------------
// tmm_datapath
// budget row memory, row update pipeline, minimum search and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_machine_makespan_dp_assert.svh"

module tmm_datapath #(
	parameter int MAX_TOTAL = tmm_pkg::MAX_TOTAL_DEF
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  tmm_pkg::cmd_t                           cmd,
	input  wire  [$clog2(MAX_TOTAL+1)-1:0]          idx,
	input  wire  [tmm_pkg::TIME_W-1:0]              task_time,
	input  wire                                     last_task,
	output logic                                    last,
	output logic [tmm_pkg::TIME_W-1:0]              makespan,
	output logic                                    overflow
);
	import tmm_pkg::*;

	localparam int AW = $clog2(MAX_TOTAL+1);
	localparam int DEPTH = MAX_TOTAL + 1;
	localparam int VW = (AW > TIME_W) ? AW : TIME_W;
	localparam int SW = VW + 1;

	logic [TIME_W-1:0] mem [DEPTH];

	logic [TIME_W-1:0] t_q;
	logic              last_q;
	logic [AW-1:0]     total_q;
	logic              ovf_q;
	logic [VW-1:0]     best_q;
	logic [TIME_W-1:0] res_span_q;
	logic              res_ovf_q;

	logic [TIME_W-1:0] rd_b_s1;
	logic [TIME_W-1:0] rd_a_s1;
	logic              a_ok_s1;
	logic [AW-1:0]     j_s1;
	logic              valid_s1;
	logic [TIME_W-1:0] new_s2;
	logic [AW-1:0]     j_s2;
	logic              valid_s2;

	logic [SW-1:0]     sum;
	logic              a_ok;
	logic [AW-1:0]     a_addr;
	logic [TIME_W:0]   to_b_raw;
	logic [TIME_W-1:0] to_b;
	logic [TIME_W-1:0] new_val;
	logic [VW-1:0]     m_val;

	assign sum = SW'(total_q) + SW'(t_q);
	assign a_ok = SW'(idx) >= SW'(t_q);
	assign a_addr = a_ok ? AW'(SW'(idx) - SW'(t_q)) : idx;

	assign to_b_raw = {1'b0, rd_b_s1} + {1'b0, t_q};
	assign to_b = to_b_raw[TIME_W] ? VAL_CAP : to_b_raw[TIME_W-1:0];
	assign new_val = (a_ok_s1 && (rd_a_s1 < to_b)) ? rd_a_s1 : to_b;

	assign m_val = (VW'(j_s2) > VW'(new_s2)) ? VW'(j_s2) : VW'(new_s2);

	// row memory: two read ports, one write port
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_b_s1 <= mem[idx];
			rd_a_s1 <= mem[a_addr];
		end
		if (cmd.clr_wr) begin
			mem[idx] <= '0;
		end else if (valid_s1) begin
			// the last task of a set leaves the row cleared
			mem[j_s1] <= last_q ? '0 : new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			total_q <= '0;
			ovf_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd;
			valid_s2 <= valid_s1;
			if (cmd.take) begin
				last_q <= last_task;
			end
			if (cmd.load_res) begin
				total_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.take) begin
				if (SW'(total_q) + SW'(task_time) > SW'(MAX_TOTAL)) begin
					total_q <= AW'(MAX_TOTAL);
					ovf_q <= 1'b1;
				end else begin
					total_q <= AW'(SW'(total_q) + SW'(task_time));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			t_q <= task_time;
			best_q <= '1;
		end else if (valid_s2 && (m_val < best_q)) begin
			best_q <= m_val;
		end
		if (cmd.rd) begin
			j_s1 <= idx;
			a_ok_s1 <= a_ok;
		end
		if (valid_s1) begin
			new_s2 <= new_val;
			j_s2 <= j_s1;
		end
		if (cmd.load_res) begin
			res_span_q <= (best_q > VW'(VAL_CAP)) ? VAL_CAP : best_q[TIME_W-1:0];
			res_ovf_q <= ovf_q;
		end
	end

	assign last = last_q;
	assign makespan = res_span_q;
	assign overflow = res_ovf_q;

	`TMM_ASSERT(a_total_range, (total_q <= AW'(MAX_TOTAL)), "running total above limit")
	`TMM_ASSERT(a_ovf_total,
		(ovf_q && !$past(cmd.load_res) |-> total_q == AW'(MAX_TOTAL)),
		"overflow without saturated total")
	`TMM_NEVER(a_wr_clash, (cmd.clr_wr && valid_s1), "clear and update writes collide")

endmodule

`default_nettype wire

// ----- hw/rtl/tmm_controller.sv -----
// ----------------------------------------------------------------------------
// tmm_controller
// sequencer for row clearing, per-task row sweeps and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_machine_makespan_dp_assert.svh"

module tmm_controller #(
	parameter int MAX_TOTAL = tmm_pkg::MAX_TOTAL_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	output logic                               out_valid,
	input  wire                                out_ready,
	input  wire                                last,
	output tmm_pkg::cmd_t                      cmd,
	output logic [$clog2(MAX_TOTAL+1)-1:0]     idx
);
	import tmm_pkg::*;

	localparam int AW = $clog2(MAX_TOTAL+1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [AW-1:0] cnt_q;
	logic          out_valid_q;
	logic          res_free;

	assign res_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign idx = cnt_q;

	always_comb begin
		cmd = '0;
		cmd.take = (state_q == ST_IDLE) && in_valid;
		cmd.rd = (state_q == ST_SCAN);
		cmd.clr_wr = (state_q == ST_CLEAR);
		cmd.load_res = (state_q == ST_FINISH) && res_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= AW'(MAX_TOTAL);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= AW'(MAX_TOTAL);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == '0) begin
						cnt_q <= AW'(1);
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DRAIN: begin
					if (cnt_q == '0) begin
						state_q <= last ? ST_FINISH : ST_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FINISH: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TMM_ASSERT(a_cmd_excl,
		($onehot0({cmd.take, cmd.rd, cmd.clr_wr, cmd.load_res})),
		"commands overlap")
	`TMM_ASSERT(a_res_free, (cmd.load_res |-> (!out_valid_q || out_ready)), "result overwritten")
	`TMM_ASSERT(a_scan_end, ((state_q == ST_SCAN && cnt_q == '0) |=> state_q == ST_DRAIN),
		"sweep did not drain")

endmodule

`default_nettype wire

// ----- hw/rtl/two_machine_makespan_dp.sv -----
// ----------------------------------------------------------------------------
// two_machine_makespan_dp
// shortest finishing time of a task set on two identical machines
// ----------------------------------------------------------------------------
// usage:
//   task_in takes one task duration per transaction; last_task marks the
//   final task of a set. result_out gives one transaction per set with the
//   makespan and the overflow flag (running total above MAX_TOTAL).
//   each task sweeps the budget row of MAX_TOTAL+1 entries, one entry per
//   cycle through a dual-read, single-write memory, then drains a two-stage
//   update pipeline; task_in.ready stays low until the sweep and the drain
//   are done (for the last task of a set, until the result is loaded), which
//   sets the throughput.
//   the result is loaded into the output register after the last sweep and
//   drain, once that register is free; the last sweep also zeroes the row.
//   after reset a clearing pass writes zeros over all MAX_TOTAL+1 row
//   entries while task_in.ready stays low.
//   if the receiver stalls, the result is held in the output register; the
//   next set's tasks are still taken and its result waits until the
//   previous one has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module two_machine_makespan_dp #(
	parameter int MAX_TOTAL = tmm_pkg::MAX_TOTAL_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	tmm_task_if.sink       task_in,
	tmm_result_if.source   result_out
);
	import tmm_pkg::*;

	localparam int AW = $clog2(MAX_TOTAL+1);

	cmd_t          cmd;
	logic [AW-1:0] idx;
	logic          last;

	tmm_controller #(
		.MAX_TOTAL (MAX_TOTAL)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (task_in.valid),
		.in_ready  (task_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.last      (last),
		.cmd       (cmd),
		.idx       (idx)
	);

	tmm_datapath #(
		.MAX_TOTAL (MAX_TOTAL)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idx       (idx),
		.task_time (task_in.task_time),
		.last_task (task_in.last_task),
		.last      (last),
		.makespan  (result_out.makespan),
		.overflow  (result_out.overflow)
	);

endmodule

`default_nettype wire

// ----- dv/tmm_makespan_checker.sv -----
// ----------------------------------------------------------------------------
// tmm_makespan_checker
// watches the task and result channels, predicts each makespan from the
// accepted tasks with its own budget-row model and compares every result
// transaction field by field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmm_makespan_checker #(
	parameter int MAX_TOTAL = tmm_pkg::MAX_TOTAL_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	tmm_task_if          task_ch,
	tmm_result_if        result_ch,
	output int unsigned  fail_count,
	output int unsigned  outstanding
);
	import tmm_pkg::*;

	typedef struct packed {
		logic [TIME_W-1:0] makespan;
		logic              overflow;
	} schedule_result_t;

	logic [TIME_W-1:0] b_need_row [0:MAX_TOTAL];
	int unsigned       set_total;
	logic              set_overflow;
	schedule_result_t  makespan_q [$];
	schedule_result_t  oldest;
	int unsigned       mismatches = 0;

	function automatic void start_new_set();
		for (int j = 0; j <= MAX_TOTAL; j++) b_need_row[j] = '0;
		set_total = 0;
		set_overflow = 1'b0;
	endfunction

	function automatic void schedule_task(input logic [TIME_W-1:0] t, input logic last);
		int unsigned to_a;
		int unsigned to_b;
		int unsigned span;
		int unsigned best;
		schedule_result_t res;
		if (set_total + int'(t) > MAX_TOTAL) begin
			set_overflow = 1'b1;
			set_total = MAX_TOTAL;
		end else begin
			set_total = set_total + int'(t);
		end
		// descending budget, so the entry j - t still holds its old value
		for (int j = MAX_TOTAL; j >= 0; j--) begin
			to_b = int'(b_need_row[j]) + int'(t);
			if (to_b > int'(VAL_CAP)) to_b = int'(VAL_CAP);
			if (j >= int'(t)) begin
				to_a = int'(b_need_row[j - int'(t)]);
				b_need_row[j] = (to_a < to_b) ? to_a[TIME_W-1:0] : to_b[TIME_W-1:0];
			end else begin
				b_need_row[j] = to_b[TIME_W-1:0];
			end
		end
		if (last) begin
			best = 32'hFFFF_FFFF;
			for (int j = 0; j <= MAX_TOTAL; j++) begin
				span = (j > int'(b_need_row[j])) ? j : int'(b_need_row[j]);
				if (span < best) best = span;
			end
			if (best > int'(VAL_CAP)) best = int'(VAL_CAP);
			res.makespan = best[TIME_W-1:0];
			res.overflow = set_overflow;
			makespan_q = {makespan_q, res};
			start_new_set();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_new_set();
			makespan_q.delete();
			outstanding <= 0;
			fail_count <= mismatches;
		end else begin
			// pop before push: a result never belongs to a task taken at the same edge
			if (result_ch.valid && result_ch.ready) begin
				if (makespan_q.size() == 0) begin
					$display("%0t: result transaction with none pending: makespan %0d overflow %0b",
						$time, result_ch.makespan, result_ch.overflow);
					mismatches++;
				end else begin
					oldest = makespan_q.pop_front();
					if (result_ch.makespan !== oldest.makespan) begin
						$display("%0t: makespan mismatch: expected %0d, actual %0d",
							$time, oldest.makespan, result_ch.makespan);
						mismatches++;
					end
					if (result_ch.overflow !== oldest.overflow) begin
						$display("%0t: overflow mismatch: expected %0b, actual %0b",
							$time, oldest.overflow, result_ch.overflow);
						mismatches++;
					end
				end
			end
			if (task_ch.valid && task_ch.ready) begin
				schedule_task(task_ch.task_time, task_ch.last_task);
			end
			fail_count <= mismatches;
			outstanding <= makespan_q.size();
		end
	end

endmodule

`default_nettype wire

// ----- dv/tb_two_machine_makespan_dp.sv -----
// ----------------------------------------------------------------------------
// tb_two_machine_makespan_dp
// drives task sets into the two-machine makespan block: a directed set of
// corner cases (empty and zero tasks, exact and exceeded totals, saturating
// durations) followed by random sets, with bursty task traffic, a stalling
// result receiver, one long receiver hold-off and drain pauses; the checker
// beside the block predicts and compares every result transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_two_machine_makespan_dp;
	import tmm_pkg::*;

	localparam int MAX_TOTAL    = MAX_TOTAL_DEF;
	localparam int RANDOM_ITEMS = 120;
	localparam int HOLD_AFTER   = 10;
	localparam int HOLD_CYCLES  = 60000;

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned burst_left;
	int unsigned random_sent;
	bit          paused_mid;

	tmm_task_if   task_ch();
	tmm_result_if result_ch();

	two_machine_makespan_dp #(
		.MAX_TOTAL(MAX_TOTAL)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.task_in   (task_ch),
		.result_out(result_ch)
	);

	tmm_makespan_checker #(
		.MAX_TOTAL(MAX_TOTAL)
	) makespan_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_ch    (task_ch),
		.result_ch  (result_ch),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#48_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic offer_task(input logic [TIME_W-1:0] t, input logic last);
		int unsigned gap;
		task_ch.valid <= 1'b1;
		task_ch.task_time <= t;
		task_ch.last_task <= last;
		do @(posedge clk); while (!task_ch.ready);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			task_ch.valid <= 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 5000) : $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
		end
	endtask

	task automatic drain_results();
		task_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic send_set(input int unsigned len, input int unsigned lo, input int unsigned hi);
		logic [TIME_W-1:0] t;
		for (int unsigned k = 0; k < len; k++) begin
			t = TIME_W'($urandom_range(hi, lo));
			offer_task(t, k == len - 1);
			random_sent++;
			if (!paused_mid && random_sent >= RANDOM_ITEMS / 2) begin
				paused_mid = 1'b1;
				drain_results();
			end
		end
	endtask

	// receiver: alternating ready phases plus one long hold-off
	initial begin : result_sink
		int unsigned taken;
		int unsigned phase_left;
		bit          held;
		taken = 0;
		phase_left = 0;
		held = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) taken++;
			if (phase_left > 0) begin
				phase_left--;
			end else if (!held && taken >= HOLD_AFTER) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				phase_left = HOLD_CYCLES;
			end else if (result_ch.ready) begin
				result_ch.ready <= 1'b0;
				phase_left = $urandom_range(0, 600);
			end else begin
				result_ch.ready <= 1'b1;
				phase_left = ($urandom_range(0, 5) == 0) ? $urandom_range(2000, 8000)
					: $urandom_range(1, 400);
			end
		end
	end

	initial begin : task_source
		int unsigned kind;
		int unsigned len;
		arst_n <= 1'b0;
		task_ch.valid <= 1'b0;
		task_ch.task_time <= '0;
		task_ch.last_task <= 1'b0;
		burst_left = 1;
		random_sent = 0;
		paused_mid = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// lone tasks: zero, saturating, exact limit, just over
		offer_task(0, 1'b1);
		offer_task(VAL_CAP, 1'b1);
		offer_task(TIME_W'(MAX_TOTAL), 1'b1);
		offer_task(TIME_W'(MAX_TOTAL + 1), 1'b1);
		// zero-length task inside a set
		offer_task(3, 1'b0);
		offer_task(3, 1'b0);
		offer_task(2, 1'b0);
		offer_task(2, 1'b0);
		offer_task(0, 1'b0);
		offer_task(2, 1'b1);
		// total exactly at the limit, then one over
		offer_task(TIME_W'(MAX_TOTAL / 2), 1'b0);
		offer_task(TIME_W'(MAX_TOTAL / 2), 1'b1);
		offer_task(TIME_W'(MAX_TOTAL - 96), 1'b0);
		offer_task(97, 1'b1);
		// alternating bit patterns
		offer_task(13'h1555, 1'b0);
		offer_task(13'h0AAA, 1'b1);
		offer_task(7, 1'b0);
		offer_task(5, 1'b0);
		offer_task(4, 1'b0);
		offer_task(3, 1'b1);
		offer_task(1, 1'b0);
		offer_task(1, 1'b1);
		offer_task(0, 1'b0);
		offer_task(0, 1'b1);
		drain_results();

		while (random_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			len = $urandom_range(1, 5);
			if (kind <= 5) begin
				send_set(len, 0, MAX_TOTAL / len);
			end else if (kind <= 7) begin
				send_set(len + 1, 0, 31);
			end else if (kind == 8) begin
				send_set(len, 0, VAL_CAP);
			end else begin
				send_set(len, MAX_TOTAL / 2, MAX_TOTAL);
			end
		end

		drain_results();
		repeat (MAX_TOTAL + 16) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tmm_pkg.sv
hw/rtl/tmm_task_if.sv
hw/rtl/tmm_result_if.sv
hw/rtl/tmm_datapath.sv
hw/rtl/tmm_controller.sv
hw/rtl/two_machine_makespan_dp.sv
dv/tmm_makespan_checker.sv
dv/tb_two_machine_makespan_dp.sv
